### rtl/aes_ctr_pkg.sv
// Shared types, constants and functions for the AES-128 counter-mode cipher.
// No dependencies.
`default_nettype none
package aes_ctr_pkg;
   localparam int RoundKeyCount = 11;
   localparam int CsrAddrWidth = 6;
   localparam logic [CsrAddrWidth-1:0] ADDR_KEY_HIGH   = 6'h00;
   localparam logic [CsrAddrWidth-1:0] ADDR_KEY_LOW    = 6'h08;
   localparam logic [CsrAddrWidth-1:0] ADDR_NONCE_HIGH = 6'h10;
   localparam logic [CsrAddrWidth-1:0] ADDR_NONCE_LOW  = 6'h18;
   localparam logic [CsrAddrWidth-1:0] ADDR_OP_MODE    = 6'h20;
   localparam logic [1:0] MODE_ADD_ONE = 2'd2;

   typedef struct packed {
      logic load;     // load counter block, add round key 0
      logic round;    // run one full round
      logic last;     // run the final round (no column mix)
      logic restart;  // reload counter from nonce before load
      logic advance;  // step the block counter
      logic capture;  // form and register the result
   } cmd_type;

   typedef struct packed {
      logic key_busy;
   } status_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return b[7] ? ({b[6:0], 1'b0} ^ 8'h1B) : {b[6:0], 1'b0};
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // One cipher round on a 128-bit state, byte 0 on top; mix selects column mixing.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) t[4*c+r] = sbox(b[4*((c+r)&3)+r]);
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
      return o ^ k;
   endfunction
endpackage
`default_nettype wire

### rtl/aes_ctr_keysched.sv
// Round key schedule: expands one round key per cycle into a register file of round keys.
// Depends on aes_ctr_pkg.
`default_nettype none
module aes_ctr_keysched #(
   parameter int ROUND_KEY_COUNT = aes_ctr_pkg::RoundKeyCount
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] key,
   input  wire logic [$clog2(ROUND_KEY_COUNT)-1:0] rd_index,
   output logic [127:0]      rd_key,
   output logic              busy
);
   import aes_ctr_pkg::*;
   localparam int IW = $clog2(ROUND_KEY_COUNT);
   localparam logic [IW-1:0] LastIdx = IW'(ROUND_KEY_COUNT - 1);

   logic [127:0] keys_ff [ROUND_KEY_COUNT];
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]    rc_ff, rc_in;
   logic          busy_ff, busy_in;
   logic [127:0]  prev, next;
   logic [31:0]   t, w0, w1, w2, w3;

   always_comb begin
      prev = keys_ff[idx_ff];
      t  = sub_word({prev[23:0], prev[31:24]}) ^ {rc_ff, 24'h0};
      w0 = prev[127:96] ^ t;
      w1 = prev[95:64] ^ w0;
      w2 = prev[63:32] ^ w1;
      w3 = prev[31:0] ^ w2;
      next = {w0, w1, w2, w3};
      busy_in = busy_ff;
      idx_in  = idx_ff;
      rc_in   = rc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         rc_in   = 8'h01;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         rc_in  = xtime(rc_ff);
         if (idx_ff == LastIdx - 1'b1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         rc_ff   <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         rc_ff   <= rc_in;
      end
      if (reset || start) keys_ff[0] <= reset ? 128'h0 : key;
      else if (busy_ff) keys_ff[idx_ff + 1'b1] <= next;
   end

   assign rd_key = keys_ff[rd_index];
   assign busy   = busy_ff;
endmodule
`default_nettype wire

### rtl/aes_ctr_datapath.sv
// Datapath: counter, cipher state register, one shared round unit, result register.
// Depends on aes_ctr_pkg and aes_ctr_keysched.
`default_nettype none
module aes_ctr_datapath #(
   parameter int ROUND_KEY_COUNT = aes_ctr_pkg::RoundKeyCount
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire aes_ctr_pkg::cmd_type cmd,
   output aes_ctr_pkg::status_type status,
   input  wire logic         key_start,
   input  wire logic [127:0] key,
   input  wire logic [127:0] nonce,
   input  wire logic [1:0]   op_mode,
   input  wire logic [127:0] data,
   input  wire logic [$clog2(ROUND_KEY_COUNT)-1:0] round_index,
   output logic [127:0]      result
);
   import aes_ctr_pkg::*;
   logic [31:0]  ctr_ff, ctr_in;
   logic [127:0] st_ff, st_in, res_ff, rk;
   logic [127:0] ks, dec;
   logic         kbusy;

   aes_ctr_keysched #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_keys (
      .clock(clock), .reset(reset), .start(key_start), .key(key),
      .rd_index(round_index), .rd_key(rk), .busy(kbusy));

   always_comb begin
      ctr_in = ctr_ff;
      if (cmd.restart) ctr_in = nonce[31:0];
      if (cmd.advance) ctr_in = ctr_ff + 32'd1;
      st_in = st_ff;
      if (cmd.load) st_in = {nonce[127:32], cmd.restart ? nonce[31:0] : ctr_ff} ^ rk;
      else if (cmd.round || cmd.last) st_in = aes_round(st_ff, rk, cmd.round);
      ks = st_ff;
      dec = data ^ ks;
      for (int i = 0; i < 16; i++) dec[8*i +: 8] = dec[8*i +: 8] + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) ctr_ff <= '0;
      else       ctr_ff <= ctr_in;
      st_ff <= st_in;
      if (cmd.capture) res_ff <= (op_mode == MODE_ADD_ONE) ? (dec ^ ks) : (data ^ ks);
   end

   assign status.key_busy = kbusy;
   assign result = res_ff;
endmodule
`default_nettype wire

### rtl/aes_ctr_ctrl.sv
// Controller: sequences load, rounds, capture and the output handshake.
// Depends on aes_ctr_pkg.
`default_nettype none
module aes_ctr_ctrl #(
   parameter int ROUND_KEY_COUNT = aes_ctr_pkg::RoundKeyCount
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic in_restart,
   output logic      out_valid,
   input  wire logic out_ready,
   input  wire aes_ctr_pkg::status_type status,
   output aes_ctr_pkg::cmd_type cmd,
   output logic [$clog2(ROUND_KEY_COUNT)-1:0] round_index
);
   import aes_ctr_pkg::*;
   localparam int IW = $clog2(ROUND_KEY_COUNT);
   localparam logic [IW-1:0] LastIdx = IW'(ROUND_KEY_COUNT - 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] rnd_ff, rnd_in;
   logic          ov_ff, ov_in;
   logic          take;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      ov_in    = ov_ff & ~out_ready;
      cmd      = '0;
      in_ready = 1'b0;
      take     = 1'b0;
      round_index = rnd_ff;
      case (state_ff)
         S_IDLE: begin
            in_ready = ~status.key_busy;
            round_index = '0;
            if (in_valid && !status.key_busy) begin
               take = 1'b1;
               cmd.load = 1'b1;
               cmd.restart = in_restart;
               rnd_in = IW'(1);
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (rnd_ff == LastIdx) begin
               cmd.last = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.round = 1'b1;
               rnd_in = rnd_ff + 1'b1;
            end
         end
         S_DONE: begin
            // wait for the result register to free up
            if (!ov_ff || out_ready) begin
               cmd.capture = 1'b1;
               cmd.advance = 1'b1;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (take) cmd.restart = in_restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rnd_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         ov_ff    <= ov_in;
      end
   end

   assign out_valid = ov_ff;
endmodule
`default_nettype wire

### rtl/aes128_ctr_cipher.sv
// Top level of the AES-128 counter-mode cipher: CSR port, controller and datapath.
// Depends on aes_ctr_pkg, aes_ctr_ctrl, aes_ctr_datapath.
//
//   channel | direction | handshake            | content
//   req     | in        | req_tvalid/tready    | tdata data, tuser restart
//   rsp     | out       | rsp_tvalid/tready    | tdata result
//   csr     | in/out    | psel/penable/pready  | 64-bit registers at 8*i
//
// A request is taken in the idle state and its result is registered after one load with
// the first round key, nine full rounds, the final round and one capture; the one shared
// round unit handles one request at a time. The result register is freed as the next
// request runs, so a slow consumer stalls only the capture step.
// After reset, and after each key write, the key schedule expands the round keys;
// no request is taken until it finishes.
`default_nettype none
module aes128_ctr_cipher #(
   parameter int ROUND_KEY_COUNT = aes_ctr_pkg::RoundKeyCount
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // data_low[63:0], data_high[127:64]
   input  wire logic         req_tuser,   // restart
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // result_low[63:0], result_high[127:64]
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [aes_ctr_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);
   import aes_ctr_pkg::*;

   logic [63:0] key_high_ff, key_low_ff, nonce_high_ff, nonce_low_ff;
   logic [1:0]  op_mode_ff;
   logic        wr, key_start;
   cmd_type     cmd;
   status_type  status;
   logic [$clog2(ROUND_KEY_COUNT)-1:0] round_index;
   logic [127:0] req_tdata_hold;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   // restart key expansion on either key half
   assign key_start = wr && (csr_paddr == ADDR_KEY_HIGH || csr_paddr == ADDR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff  <= '0;
         op_mode_ff    <= '0;
      end else if (wr) begin
         case (csr_paddr)
            ADDR_KEY_HIGH:   key_high_ff   <= csr_pwdata;
            ADDR_KEY_LOW:    key_low_ff    <= csr_pwdata;
            ADDR_NONCE_HIGH: nonce_high_ff <= csr_pwdata;
            ADDR_NONCE_LOW:  nonce_low_ff  <= csr_pwdata;
            ADDR_OP_MODE:    op_mode_ff    <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_KEY_HIGH:   csr_prdata = key_high_ff;
         ADDR_KEY_LOW:    csr_prdata = key_low_ff;
         ADDR_NONCE_HIGH: csr_prdata = nonce_high_ff;
         ADDR_NONCE_LOW:  csr_prdata = nonce_low_ff;
         ADDR_OP_MODE:    csr_prdata = {62'h0, op_mode_ff};
         default:         csr_prdata = '0;
      endcase
   end

   aes_ctr_ctrl #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_restart(req_tuser),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .status(status), .cmd(cmd), .round_index(round_index));

   // the key written in this cycle is taken from pwdata directly
   aes_ctr_datapath #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .key_start(key_start),
      .key(csr_paddr == ADDR_KEY_HIGH ? {csr_pwdata, key_low_ff} : {key_high_ff, csr_pwdata}),
      .nonce({nonce_high_ff, nonce_low_ff}), .op_mode(op_mode_ff),
      .data(req_tdata_hold), .round_index(round_index), .result(rsp_tdata));

   // hold the accepted request data for the capture step
   always_ff @(posedge clock) begin
      if (cmd.load) req_tdata_hold <= req_tdata;
   end
endmodule
`default_nettype wire
